>>> rtl/assert_macros.svh
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCC_ASSERT_IMP(name, lhs, rhs, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) else $error(msg);

// implication after a fixed number of cycles
`define TCC_ASSERT_DLY(name, lhs, dly, rhs, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> ##(dly) (rhs)) \
        else $error(msg);

`endif

>>> rtl/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

    // coordinate width and derived datapath widths
    localparam int CW   = 32;
    localparam int AW   = CW + 1;
    localparam int NW   = 2 * AW + 1;
    localparam int SQW  = 2 * AW + 2;
    localparam int NNW  = 2 * NW + 2;
    localparam int WW   = SQW + AW + 1;
    localparam int NUMW = WW + NW + 1;
    localparam int DENW = NNW + 1;
    localparam int QB   = CW + 2;
    localparam int CMPW = DENW + QB;

    // multiplier digit and pipeline lengths
    localparam int MUL_DIG  = 8;
    localparam int M1_LAT   = (AW + MUL_DIG - 1) / MUL_DIG + 2;
    localparam int M2_LAT   = (NW + MUL_DIG - 1) / MUL_DIG + 2;
    localparam int DIV_LAT  = QB + 3;
    localparam int BACK_LAT = M1_LAT + 1 + 2 * (M2_LAT + 1) + DIV_LAT + 1;
    localparam int LATENCY  = BACK_LAT + 2;

    // queue between front and back, power of two
    localparam int Q_DEPTH = 2;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic   kind;
        coord_t first_x;
        coord_t first_y;
        coord_t first_z;
        coord_t second_x;
        coord_t second_y;
        coord_t second_z;
        coord_t third_x;
        coord_t third_y;
        coord_t third_z;
    } item_t;

    typedef struct packed {
        coord_t center_x;
        coord_t center_y;
        coord_t center_z;
        logic   degenerate;
        logic   saturated;
    } result_t;

    // base vertex and the edge vectors a and b
    typedef struct packed {
        logic [2:0][CW-1:0] base;
        logic [2:0][AW-1:0] a;
        logic [2:0][AW-1:0] b;
    } work_t;

endpackage

`default_nettype wire

>>> rtl/tcc_delay.sv
`default_nettype none

module tcc_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [N];

    // plain shift line
    always_ff @(posedge clk)
    begin
        pipe_reg[0] <= d;
        for (int i = 1; i < N; i++)
        begin
            pipe_reg[i] <= pipe_reg[i-1];
        end
    end

    assign q = pipe_reg[N-1];

endmodule

`default_nettype wire

>>> rtl/tcc_mul.sv
`default_nettype none

module tcc_mul #(
    parameter int A_WIDTH = tcc_pkg::AW,
    parameter int B_WIDTH = tcc_pkg::AW
) (
    input  logic                              clk,
    input  logic signed [A_WIDTH-1:0]         a,
    input  logic signed [B_WIDTH-1:0]         b,
    output logic signed [A_WIDTH+B_WIDTH-1:0] p
);
    import tcc_pkg::*;

    localparam int NST = (B_WIDTH + MUL_DIG - 1) / MUL_DIG;
    localparam int BPW = NST * MUL_DIG;
    localparam int PRW = A_WIDTH + MUL_DIG + 1;
    localparam int ACW = A_WIDTH + BPW + 1;
    localparam int PW  = A_WIDTH + B_WIDTH;

    logic        [B_WIDTH-1:0] b_mag;
    logic signed [A_WIDTH-1:0] a_reg   [NST];
    logic        [BPW-1:0]     b_reg   [NST];
    logic                      neg_reg [NST+1];
    logic signed [ACW-1:0]     acc_reg [NST];
    logic signed [PRW-1:0]     prod    [NST];
    logic signed [ACW-1:0]     term    [NST];
    logic signed [PW-1:0]      p_reg;

    // magnitude of the multiplier operand
    always_comb
    begin
        b_mag = b[B_WIDTH-1] ? B_WIDTH'(-b) : B_WIDTH'(b);
    end

    // one partial product per stage, one digit of b each
    always_comb
    begin
        for (int j = 0; j < NST; j++)
        begin
            prod[j] = a_reg[j] * $signed({1'b0, b_reg[j][MUL_DIG-1:0]});
            term[j] = ACW'(prod[j]) <<< (MUL_DIG * j);
        end
    end

    // operand stage, accumulate stages, sign fix
    always_ff @(posedge clk)
    begin
        a_reg[0]   <= a;
        b_reg[0]   <= BPW'(b_mag);
        neg_reg[0] <= b[B_WIDTH-1];
        acc_reg[0] <= term[0];
        for (int j = 1; j < NST; j++)
        begin
            a_reg[j]   <= a_reg[j-1];
            b_reg[j]   <= b_reg[j-1] >> MUL_DIG;
            acc_reg[j] <= acc_reg[j-1] + term[j];
        end
        for (int j = 1; j <= NST; j++)
        begin
            neg_reg[j] <= neg_reg[j-1];
        end
        p_reg <= neg_reg[NST] ? PW'(-acc_reg[NST-1]) : PW'(acc_reg[NST-1]);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> rtl/tcc_div.sv
`default_nettype none

module tcc_div (
    input  logic                            clk,
    input  logic signed [tcc_pkg::NUMW-1:0] num,
    input  logic [tcc_pkg::DENW-1:0]        den,
    input  tcc_pkg::coord_t                 base,
    output tcc_pkg::coord_t                 coord,
    output logic                            sat
);
    import tcc_pkg::*;

    localparam int SW = QB + 3;
    localparam logic signed [SW-1:0] HI_LIM = {{(SW-CW){1'b0}}, 1'b0, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] LO_LIM = {{(SW-CW){1'b1}}, 1'b1, {(CW-1){1'b0}}};
    localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

    logic [NUMW-1:0] mag;
    logic [CMPW-1:0] r_reg    [QB+1];
    logic [QB-1:0]   q_reg    [QB+1];
    logic [DENW-1:0] den_reg  [QB+1];
    logic            neg_reg  [QB+1];
    logic            ovf_reg  [QB+1];
    coord_t          base_reg [QB+1];
    logic [CMPW-1:0] shd      [QB+1];
    logic            ge       [QB+1];

    logic                 rup;
    logic [QB:0]          qr;
    logic signed [QB+1:0] off_next;
    logic signed [QB+1:0] off_reg;
    logic                 ovf_rnd_reg;
    logic                 neg_rnd_reg;
    coord_t               base_rnd_reg;
    logic signed [SW-1:0] sum;
    coord_t               coord_next;
    logic                 sat_next;
    coord_t               coord_reg;
    logic                 sat_reg;

    always_comb
    begin
        mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    end

    // divisor shifted to the bit that each stage decides
    always_comb
    begin
        shd[0] = '0;
        ge[0]  = 1'b0;
        for (int s = 1; s <= QB; s++)
        begin
            shd[s] = CMPW'(den_reg[s-1]) << (QB - s);
            ge[s]  = r_reg[s-1] >= shd[s];
        end
    end

    // rounding, ties away from zero, then sign
    always_comb
    begin
        rup      = {r_reg[QB], 1'b0} >= (CMPW+1)'(den_reg[QB]);
        qr       = (QB+1)'(q_reg[QB]) + (QB+1)'(rup);
        off_next = $signed({1'b0, qr});
        if (neg_reg[QB])
        begin
            off_next = -off_next;
        end
    end

    // add base vertex and clamp
    always_comb
    begin
        sum        = SW'(base_rnd_reg) + SW'(off_reg);
        coord_next = sum[CW-1:0];
        sat_next   = 1'b0;
        priority if (ovf_rnd_reg)
        begin
            sat_next   = 1'b1;
            coord_next = neg_rnd_reg ? CMIN : CMAX;
        end
        else if (sum > HI_LIM)
        begin
            sat_next   = 1'b1;
            coord_next = CMAX;
        end
        else if (sum < LO_LIM)
        begin
            sat_next   = 1'b1;
            coord_next = CMIN;
        end
    end

    // magnitude and overflow stage, restoring steps, round, clamp
    always_ff @(posedge clk)
    begin
        r_reg[0]    <= CMPW'(mag);
        q_reg[0]    <= '0;
        den_reg[0]  <= den;
        neg_reg[0]  <= num[NUMW-1];
        ovf_reg[0]  <= CMPW'(mag) >= {den, {QB{1'b0}}};
        base_reg[0] <= base;
        for (int s = 1; s <= QB; s++)
        begin
            r_reg[s]    <= ge[s] ? r_reg[s-1] - shd[s] : r_reg[s-1];
            q_reg[s]    <= q_reg[s-1] | (QB'(ge[s]) << (QB - s));
            den_reg[s]  <= den_reg[s-1];
            neg_reg[s]  <= neg_reg[s-1];
            ovf_reg[s]  <= ovf_reg[s-1];
            base_reg[s] <= base_reg[s-1];
        end
        off_reg      <= off_next;
        ovf_rnd_reg  <= ovf_reg[QB];
        neg_rnd_reg  <= neg_reg[QB];
        base_rnd_reg <= base_reg[QB];
        coord_reg    <= coord_next;
        sat_reg      <= sat_next;
    end

    assign coord = coord_reg;
    assign sat   = sat_reg;

endmodule

`default_nettype wire

>>> rtl/tcc_front.sv
`default_nettype none

module tcc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tcc_pkg::item_t  item,
    input  logic            full,
    output logic            busy,
    output logic            push,
    output tcc_pkg::work_t  word
);
    import tcc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    logic  accept;
    work_t word_reg;
    work_t word_next;
    logic [2:0][CW-1:0] p0;
    logic [2:0][CW-1:0] p1;
    logic [2:0][CW-1:0] p2;

    // handshake
    always_comb
    begin
        busy       = valid_reg && full;
        push       = valid_reg && !full;
        accept     = start && !busy;
        valid_next = valid_reg;
        priority if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    // planar items drop z, then edge vectors from the first vertex
    always_comb
    begin
        p0 = {item.kind ? item.first_z  : '0, item.first_y,  item.first_x};
        p1 = {item.kind ? item.second_z : '0, item.second_y, item.second_x};
        p2 = {item.kind ? item.third_z  : '0, item.third_y,  item.third_x};
        word_next.base = p0;
        for (int k = 0; k < 3; k++)
        begin
            word_next.a[k] = {p1[k][CW-1], p1[k]} - {p0[k][CW-1], p0[k]};
            word_next.b[k] = {p2[k][CW-1], p2[k]} - {p0[k][CW-1], p0[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

>>> rtl/tcc_queue.sv
`default_nettype none

module tcc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tcc_pkg::work_t  wdata,
    output logic            full,
    output logic            rvalid,
    output tcc_pkg::work_t  rdata
);
    import tcc_pkg::*;

    localparam int PTRW = $clog2(Q_DEPTH);
    localparam int CNTW = $clog2(Q_DEPTH + 1);

    work_t           mem [Q_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            pop;

    // the back end drains a word every cycle one is present
    always_comb
    begin
        rvalid     = count_reg != '0;
        pop        = rvalid;
        full       = count_reg == CNTW'(Q_DEPTH);
        rdata      = mem[rd_ptr_reg];
        count_next = count_reg;
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers wrap naturally
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tcc_back.sv
`default_nettype none

module tcc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  tcc_pkg::work_t   word,
    output logic             valid,
    output tcc_pkg::result_t result
);
    import tcc_pkg::*;

    typedef struct packed {
        logic [2:0][NW-1:0] n;
        logic [2:0][CW-1:0] base;
    } side2_t;

    typedef struct packed {
        logic [NNW-1:0]     nn;
        logic [2:0][CW-1:0] base;
    } side3_t;

    // step one: cross product and squared edge lengths
    logic signed [2*AW-1:0] pn_p [3];
    logic signed [2*AW-1:0] pn_m [3];
    logic signed [2*AW-1:0] sa   [3];
    logic signed [2*AW-1:0] sb   [3];
    work_t                  s1;
    logic [2:0][NW-1:0]     n1_reg;
    logic [SQW-1:0]         aa1_reg;
    logic [SQW-1:0]         bb1_reg;
    logic [2:0][AW-1:0]     a1_reg;
    logic [2:0][AW-1:0]     b1_reg;
    logic [2:0][CW-1:0]     base1_reg;

    // step two: |n|^2 and w = |a|^2 b - |b|^2 a
    logic signed [2*NW-1:0]     nsq  [3];
    logic signed [SQW+NW-1:0]   wp   [3];
    logic signed [SQW+NW-1:0]   wm   [3];
    side2_t                     s2;
    logic [NNW-1:0]             nn2_reg;
    logic [2:0][WW-1:0]         w2_reg;
    logic [2:0][NW-1:0]         n2_reg;
    logic [2:0][CW-1:0]         base2_reg;

    // step three: numerators w x n
    logic signed [WW+NW-1:0] up   [3];
    logic signed [WW+NW-1:0] um   [3];
    side3_t                  s3;
    logic [2:0][NUMW-1:0]    num3_reg;
    logic [DENW-1:0]         den3_reg;
    logic                    deg3_reg;
    logic [2:0][CW-1:0]      base3_reg;

    // step four: division and output
    coord_t               cc  [3];
    logic                 cs  [3];
    logic                 deg4;
    result_t              result_reg;
    logic [BACK_LAT-1:0]  vld_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_step1
        localparam int I = (k + 1) % 3;
        localparam int J = (k + 2) % 3;
        tcc_mul #(.A_WIDTH(AW), .B_WIDTH(AW)) u_np (
            .clk(clk), .a($signed(word.a[I])), .b($signed(word.b[J])), .p(pn_p[k]));
        tcc_mul #(.A_WIDTH(AW), .B_WIDTH(AW)) u_nm (
            .clk(clk), .a($signed(word.a[J])), .b($signed(word.b[I])), .p(pn_m[k]));
        tcc_mul #(.A_WIDTH(AW), .B_WIDTH(AW)) u_sa (
            .clk(clk), .a($signed(word.a[k])), .b($signed(word.a[k])), .p(sa[k]));
        tcc_mul #(.A_WIDTH(AW), .B_WIDTH(AW)) u_sb (
            .clk(clk), .a($signed(word.b[k])), .b($signed(word.b[k])), .p(sb[k]));
    end

    tcc_delay #(.W($bits(work_t)), .N(M1_LAT)) u_side1 (.clk(clk), .d(word), .q(s1));

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            n1_reg[k] <= NW'(pn_p[k]) - NW'(pn_m[k]);
        end
        aa1_reg   <= SQW'(sa[0]) + SQW'(sa[1]) + SQW'(sa[2]);
        bb1_reg   <= SQW'(sb[0]) + SQW'(sb[1]) + SQW'(sb[2]);
        a1_reg    <= s1.a;
        b1_reg    <= s1.b;
        base1_reg <= s1.base;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_step2
        tcc_mul #(.A_WIDTH(NW), .B_WIDTH(NW)) u_nsq (
            .clk(clk), .a($signed(n1_reg[k])), .b($signed(n1_reg[k])), .p(nsq[k]));
        tcc_mul #(.A_WIDTH(SQW), .B_WIDTH(NW)) u_wp (
            .clk(clk), .a($signed(aa1_reg)), .b(NW'($signed(b1_reg[k]))), .p(wp[k]));
        tcc_mul #(.A_WIDTH(SQW), .B_WIDTH(NW)) u_wm (
            .clk(clk), .a($signed(bb1_reg)), .b(NW'($signed(a1_reg[k]))), .p(wm[k]));
    end

    tcc_delay #(.W($bits(side2_t)), .N(M2_LAT)) u_side2 (
        .clk(clk), .d({n1_reg, base1_reg}), .q(s2));

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            w2_reg[k] <= WW'(wp[k]) - WW'(wm[k]);
        end
        nn2_reg   <= NNW'(nsq[0]) + NNW'(nsq[1]) + NNW'(nsq[2]);
        n2_reg    <= s2.n;
        base2_reg <= s2.base;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_step3
        localparam int I = (k + 1) % 3;
        localparam int J = (k + 2) % 3;
        tcc_mul #(.A_WIDTH(WW), .B_WIDTH(NW)) u_up (
            .clk(clk), .a($signed(w2_reg[I])), .b($signed(n2_reg[J])), .p(up[k]));
        tcc_mul #(.A_WIDTH(WW), .B_WIDTH(NW)) u_um (
            .clk(clk), .a($signed(w2_reg[J])), .b($signed(n2_reg[I])), .p(um[k]));
    end

    tcc_delay #(.W($bits(side3_t)), .N(M2_LAT)) u_side3 (
        .clk(clk), .d({nn2_reg, base2_reg}), .q(s3));

    // denominator is 2 |n|^2, zero means collinear points
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            num3_reg[k] <= NUMW'(up[k]) - NUMW'(um[k]);
        end
        den3_reg  <= {s3.nn, 1'b0};
        deg3_reg  <= s3.nn == '0;
        base3_reg <= s3.base;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        tcc_div u_div (
            .clk(clk),
            .num($signed(num3_reg[k])),
            .den(den3_reg),
            .base($signed(base3_reg[k])),
            .coord(cc[k]),
            .sat(cs[k])
        );
    end

    tcc_delay #(.W(1), .N(DIV_LAT)) u_side4 (.clk(clk), .d(deg3_reg), .q(deg4));

    // result register
    always_ff @(posedge clk)
    begin
        if (deg4)
        begin
            result_reg <= '{center_x: '0, center_y: '0, center_z: '0,
                            degenerate: 1'b1, saturated: 1'b0};
        end
        else
        begin
            result_reg <= '{center_x: cc[0], center_y: cc[1], center_z: cc[2],
                            degenerate: 1'b0, saturated: cs[0] | cs[1] | cs[2]};
        end
    end

    // word tracking down the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[BACK_LAT-2:0], in_valid};
        end
    end

    assign valid  = vld_reg[BACK_LAT-1];
    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/triangle_circumcenter.sv
// done rises once a taken start has passed the front register, a queue slot
// and then the 70-stage back pipeline
// throughput: one word per cycle, set by the fully pipelined multipliers and dividers
// busy stays low in normal use since the back end drains the queue every cycle
// reset clears the control state only; data registers keep what they hold
`default_nettype none

`include "assert_macros.svh"

module triangle_circumcenter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  tcc_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output tcc_pkg::result_t result
);
    import tcc_pkg::*;

    work_t front_word;
    work_t queue_word;
    logic  push;
    logic  full;
    logic  queue_valid;

    // accept and classify
    tcc_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .full(full),
        .busy(busy),
        .push(push),
        .word(front_word)
    );

    // decoupling queue
    tcc_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .wdata(front_word),
        .full(full),
        .rvalid(queue_valid),
        .rdata(queue_word)
    );

    // arithmetic pipeline
    tcc_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(queue_valid),
        .word(queue_word),
        .valid(done),
        .result(result)
    );

    `TCC_ASSERT_DLY(a_fixed_latency, start && !busy, LATENCY, done, "result missing at expected cycle")
    `TCC_ASSERT_DLY(a_planar_z, start && !busy && !item.kind, LATENCY, result.center_z == '0, "planar z not zero")
    `TCC_ASSERT_IMP(a_degenerate_zero, done && result.degenerate, result.center_x == '0 && result.center_y == '0 && result.center_z == '0 && !result.saturated, "degenerate result not cleared")

endmodule

`default_nettype wire

>>> verif/tb_triangle_circumcenter.sv
`default_nettype none

module tb_triangle_circumcenter;
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    // circumcenter predictor and store of pending centers
    class center_board;
        result_t pending[$];
        int      errors;
        int      checked;
        int      n_degen;
        int      n_sat;
        int      n_spatial;

        task report(string what);
            $display("mismatch @%0t: %s", $time, what);
            errors++;
        endtask

        // exact circumcenter, rounded half away from zero, then clamped
        function result_t circumcenter(item_t w);
            logic signed [255:0] p[3][3];
            logic signed [255:0] a[3], b[3], n[3], wv[3];
            logic signed [255:0] aa, bb, nn, den, num, mag, q, r, c;
            logic signed [255:0] hi, lo;
            result_t res;
            int i, j;
            hi = 256'sd2147483647;
            lo = -hi - 1;
            p[0][0] = w.first_x;  p[0][1] = w.first_y;  p[0][2] = w.first_z;
            p[1][0] = w.second_x; p[1][1] = w.second_y; p[1][2] = w.second_z;
            p[2][0] = w.third_x;  p[2][1] = w.third_y;  p[2][2] = w.third_z;
            // planar mode ignores z
            if (!w.kind)
            begin
                for (int v = 0; v < 3; v++)
                    p[v][2] = '0;
            end
            for (int k = 0; k < 3; k++)
            begin
                a[k] = p[1][k] - p[0][k];
                b[k] = p[2][k] - p[0][k];
            end
            aa = '0; bb = '0; nn = '0;
            for (int k = 0; k < 3; k++)
            begin
                i = (k + 1) % 3; j = (k + 2) % 3;
                n[k] = a[i] * b[j] - a[j] * b[i];
            end
            for (int k = 0; k < 3; k++)
            begin
                aa += a[k] * a[k];
                bb += b[k] * b[k];
                nn += n[k] * n[k];
            end
            res = '0;
            if (nn == 0)
            begin
                res.degenerate = 1'b1;
                return res;
            end
            den = nn + nn;
            for (int k = 0; k < 3; k++)
                wv[k] = aa * b[k] - bb * a[k];
            for (int k = 0; k < 3; k++)
            begin
                i = (k + 1) % 3; j = (k + 2) % 3;
                num = wv[i] * n[j] - wv[j] * n[i];
                mag = (num < 0) ? -num : num;
                q = mag / den;
                r = mag % den;
                if (r + r >= den)
                    q = q + 1;
                c = p[0][k] + ((num < 0) ? -q : q);
                if (c > hi)
                begin
                    c = hi;
                    res.saturated = 1'b1;
                end
                else if (c < lo)
                begin
                    c = lo;
                    res.saturated = 1'b1;
                end
                case (k)
                    0: res.center_x = c[31:0];
                    1: res.center_y = c[31:0];
                    default: res.center_z = c[31:0];
                endcase
            end
            return res;
        endfunction

        function void note(item_t w);
            result_t e;
            e = circumcenter(w);
            if (e.degenerate) n_degen++;
            if (e.saturated) n_sat++;
            if (w.kind) n_spatial++;
            pending.push_back(e);
        endfunction

        task check(result_t got);
            result_t e;
            if (pending.size() == 0)
            begin
                report("center word with nothing pending");
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.center_x !== e.center_x)
                report($sformatf("center_x %h want %h", got.center_x, e.center_x));
            if (got.center_y !== e.center_y)
                report($sformatf("center_y %h want %h", got.center_y, e.center_y));
            if (got.center_z !== e.center_z)
                report($sformatf("center_z %h want %h", got.center_z, e.center_z));
            if (got.degenerate !== e.degenerate)
                report($sformatf("degenerate %b want %b", got.degenerate, e.degenerate));
            if (got.saturated !== e.saturated)
                report($sformatf("saturated %b want %b", got.saturated, e.saturated));
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    item_t   item;
    logic    busy;
    logic    done;
    result_t result;

    center_board board;

    triangle_circumcenter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check(result);
    end

    // run limit
    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // offer one word and hold it until taken
    task automatic send_word(item_t w);
        start <= 1'b1;
        item  <= w;
        do @(posedge clk); while (busy);
        board.note(w);
    endtask

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            2: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
            default: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic item_t rnd_triangle();
        item_t w;
        int    mode;
        int    shape;
        coord_t dx, dy, dz;
        int    m;
        mode  = $urandom_range(0, 9);
        mode  = (mode < 2) ? 0 : (mode < 6) ? 1 : (mode < 9) ? 2 : 3;
        shape = $urandom_range(0, 9);
        w.kind     = $urandom_range(0, 1);
        w.first_x  = rnd_coord(mode); w.first_y  = rnd_coord(mode);
        w.first_z  = rnd_coord(mode);
        w.second_x = rnd_coord(mode); w.second_y = rnd_coord(mode);
        w.second_z = rnd_coord(mode);
        w.third_x  = rnd_coord(mode); w.third_y  = rnd_coord(mode);
        w.third_z  = rnd_coord(mode);
        if (shape == 0)
        begin
            // collinear: third = first + m * (second - first)
            dx = rnd_coord(1); dy = rnd_coord(1); dz = rnd_coord(1);
            m  = $signed($urandom_range(0, 8)) - 4;
            w.first_x  = rnd_coord(2); w.first_y = rnd_coord(2); w.first_z = rnd_coord(2);
            w.second_x = w.first_x + dx; w.second_y = w.first_y + dy;
            w.second_z = w.first_z + dz;
            w.third_x  = w.first_x + m * dx; w.third_y = w.first_y + m * dy;
            w.third_z  = w.first_z + m * dz;
        end
        else if (shape == 1)
        begin
            // two vertices coincide
            w.third_x = w.first_x; w.third_y = w.first_y; w.third_z = w.first_z;
        end
        return w;
    endfunction

    function automatic item_t tri_of(logic k, coord_t x1, coord_t y1, coord_t z1,
                                     coord_t x2, coord_t y2, coord_t z2,
                                     coord_t x3, coord_t y3, coord_t z3);
        item_t w;
        w.kind = k;
        w.first_x = x1;  w.first_y = y1;  w.first_z = z1;
        w.second_x = x2; w.second_y = y2; w.second_z = z2;
        w.third_x = x3;  w.third_y = y3;  w.third_z = z3;
        return w;
    endfunction

    initial
    begin
        item_t w;
        int    burst;
        bit    drained;
        coord_t mx, mn, one;
        board = new();
        start = 1'b0;
        item  = '0;
        rst_n = 1'b0;
        drained = 1'b0;
        mx  = 32'sh7fffffff;
        mn  = 32'sh80000000;
        one = 32'sh10000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: right triangles, planar and spatial, degenerate, extremes
        send_word(tri_of(0, 0, 0, 0, 2 * one, 0, 0, 0, 2 * one, 0));
        send_word(tri_of(1, 0, 0, 0, 2 * one, 0, 0, 0, 0, 2 * one));
        send_word(tri_of(0, 0, 0, 5, 2 * one, 0, -7, 0, 2 * one, 9));
        send_word(tri_of(1, one, one, one, one, one, one, one, one, one));
        send_word(tri_of(0, 0, 0, 0, one, one, 0, 3 * one, 3 * one, 0));
        send_word(tri_of(1, 0, 0, 0, one, one, one, -one, -one, -one));
        send_word(tri_of(0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_word(tri_of(0, 0, 0, 0, 3, 0, 0, 0, 1, 0));
        send_word(tri_of(0, 0, 0, 0, -3, 0, 0, 0, -1, 0));
        send_word(tri_of(0, mx, mx, mx, mn, mn, mn, mx, mn, mx));
        send_word(tri_of(1, mx, mx, mx, mn, mn, mn, mx, mn, mx));
        send_word(tri_of(1, mn, mx, mn, mx, mn, mx, mn, mn, mx));
        send_word(tri_of(0, mx, 0, 0, mx, 1, 0, mx - 1, 0, 0));
        send_word(tri_of(0, 0, 0, 0, 1, 0, 0, 2, 1, 0));
        send_word(tri_of(1, 0, 0, 0, 1, 1, 0, 2, 0, 1));
        send_word(tri_of(0, mn, mn, 0, mn, mn + 1, 0, mn + 1, mn, 0));
        send_word(tri_of(1, -1, -1, -1, -1, -1, -1, 0, 0, 0));
        send_word(tri_of(1, 32'shffffffff, 0, mx, 0, 32'shffffffff, mn, 1, 1, 1));

        // random bursts with random gaps
        for (int n = 0; n < 2000; )
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int b = 0; b < burst && n < 2000; b++, n++)
            begin
                w = rnd_triangle();
                send_word(w);
            end
            if (!drained && n >= 1000)
            begin
                // drain the whole pipeline once
                drained = 1'b1;
                start <= 1'b0;
                while (board.pending.size() != 0)
                    @(posedge clk);
            end
            else if ($urandom_range(0, 2) != 0)
                pause($urandom_range(1, 12));
        end
        start <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        $display("checked %0d centers: %0d spatial, %0d degenerate, %0d clamped",
                 board.checked, board.n_spatial, board.n_degen, board.n_sat);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
